// ===== rtl/krt_pkg.sv =====
// Types shared by the keyed record table controller and datapath.
// No dependencies.
`default_nettype none
package krt_pkg;
	localparam int unsigned VAL_BITS = 16;
	localparam int unsigned CNT_BITS = 8;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_UPDATE = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_REPORT = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SEARCH,
		OP_READ,
		OP_WRITE,
		OP_SHIFT,
		OP_RANK1,
		OP_RANK2
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   scan_start;
		logic   drop_count;
		logic   bump_count;
		logic   capture_old;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic full;
	} dp_status_t;
endpackage
`default_nettype wire

// ===== rtl/krt_ram.sv =====
// Generic single-port RAM with a registered read.
// No dependencies.
`default_nettype none
module krt_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/krt_datapath.sv =====
// Datapath of the keyed record table: key and value RAMs, scan pointer,
// search, shift and ranking registers. Depends on krt_pkg and krt_ram.
`default_nettype none
module krt_datapath #(
	parameter int unsigned ENTRIES  = 128,
	parameter int unsigned KEY_BITS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire krt_pkg::dp_cmd_t       cmd,
	output krt_pkg::dp_status_t         sts,
	input  wire logic [1:0]             in_req,
	input  wire logic [63:0]            in_key,
	input  wire logic [15:0]            in_dur,
	output logic      [15:0]            old_q,
	output logic      [7:0]             total,
	output logic      [KEY_BITS-1:0]    mn_key_q,
	output logic      [15:0]            mn_val_q,
	output logic      [KEY_BITS-1:0]    mx_key_q,
	output logic      [15:0]            mx_val_q,
	output logic      [KEY_BITS-1:0]    smn_key_q,
	output logic      [15:0]            smn_val_q,
	output logic      [KEY_BITS-1:0]    smx_key_q,
	output logic      [15:0]            smx_val_q,
	output logic                        mn_ok_q,
	output logic                        smn_ok_q,
	output logic                        smx_ok_q
);
	import krt_pkg::*;
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;     // address issued this cycle
	logic [CW-1:0]       rptr_q;    // address of data now on rdata
	logic                rvalid_q;
	logic [1:0]          req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [15:0]         dur_q;
	logic [CW-1:0]       hit_q;
	logic                found_q;
	logic [CW-1:0]       mn_idx_q, mx_idx_q;
	logic                mx_ok_q;

	logic                we;
	logic [AW-1:0]       addr;
	logic [KEY_BITS-1:0] kw, kr;
	logic [15:0]         vw, vr;
	logic [CW-1:0]       end_cnt;
	logic                rd_in;

	krt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_keys (
		.clk(clk), .we(we), .addr(addr), .wdata(kw), .rdata(kr));
	krt_ram #(.WIDTH(VAL_BITS), .DEPTH(ENTRIES)) u_vals (
		.clk(clk), .we(we), .addr(addr), .wdata(vw), .rdata(vr));

	// Shift alternates: read entry ptr, then write it one place down next cycle.
	always_comb begin
		we   = 1'b0;
		kw   = key_q;
		vw   = dur_q;
		addr = ptr_q[AW-1:0];
		if (cmd.op == OP_WRITE) begin
			we = 1'b1;
			addr = (req_q == REQ_INSERT) ? count_q[AW-1:0] : hit_q[AW-1:0];
		end else if (cmd.op == OP_READ) begin
			addr = hit_q[AW-1:0];
		end else if (cmd.op == OP_SHIFT && rvalid_q) begin
			we   = 1'b1;
			addr = rptr_q[AW-1:0] - AW'(1);
			kw   = kr;
			vw   = vr;
		end
	end

	assign end_cnt = count_q;
	assign rd_in = (ptr_q < end_cnt) && !cmd.scan_start && (cmd.op == OP_SEARCH
		|| (cmd.op == OP_SHIFT && !rvalid_q) || cmd.op == OP_RANK1 || cmd.op == OP_RANK2);

	assign sts.scan_done = !cmd.scan_start && !rvalid_q && (ptr_q >= end_cnt);
	assign sts.found     = found_q;
	assign sts.full      = (count_q >= CW'(ENTRIES));
	assign total         = 8'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ptr_q    <= '0;
			rptr_q   <= '0;
			rvalid_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.bump_count) count_q <= count_q + CW'(1);
			if (cmd.drop_count) count_q <= count_q - CW'(1);
			rptr_q   <= ptr_q;
			rvalid_q <= rd_in;
			if (cmd.scan_start) begin
				ptr_q    <= (cmd.op == OP_SHIFT) ? hit_q + CW'(1) : '0;
				rvalid_q <= 1'b0;
				if (cmd.op == OP_SEARCH) found_q <= 1'b0;
			end else if (rd_in) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.op == OP_SEARCH && rvalid_q && !found_q && kr == key_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			req_q <= in_req;
			key_q <= in_key[KEY_BITS-1:0];
			dur_q <= in_dur;
			old_q <= '0;
		end
		if (cmd.capture_old) old_q <= vr;
		if (cmd.op == OP_SEARCH && rvalid_q && !found_q && kr == key_q) hit_q <= rptr_q;
		if (cmd.op == OP_SEARCH && cmd.scan_start) begin
			mn_ok_q <= 1'b0; mx_ok_q <= 1'b0; smn_ok_q <= 1'b0; smx_ok_q <= 1'b0;
		end
		if (cmd.op == OP_RANK1 && cmd.scan_start) begin
			mn_ok_q <= 1'b0; mx_ok_q <= 1'b0;
		end
		if (cmd.op == OP_RANK2 && cmd.scan_start) begin
			smn_ok_q <= 1'b0; smx_ok_q <= 1'b0;
		end
		if (cmd.op == OP_RANK1 && rvalid_q) begin
			if (!mn_ok_q || vr < mn_val_q) begin
				mn_ok_q <= 1'b1; mn_val_q <= vr; mn_key_q <= kr; mn_idx_q <= rptr_q;
			end
			if (!mx_ok_q || vr > mx_val_q) begin
				mx_ok_q <= 1'b1; mx_val_q <= vr; mx_key_q <= kr; mx_idx_q <= rptr_q;
			end
		end
		if (cmd.op == OP_RANK2 && rvalid_q) begin
			if (rptr_q != mn_idx_q && (!smn_ok_q || vr < smn_val_q)) begin
				smn_ok_q <= 1'b1; smn_val_q <= vr; smn_key_q <= kr;
			end
			if (rptr_q != mx_idx_q && (!smx_ok_q || vr > smx_val_q)) begin
				smx_ok_q <= 1'b1; smx_val_q <= vr; smx_key_q <= kr;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/krt_ctrl.sv =====
// Controller of the keyed record table: sequences load, search, write or
// shift, two ranking passes and the result. Depends on krt_pkg.
`default_nettype none
module krt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire logic [1:0]          in_req,
	output krt_pkg::dp_cmd_t         cmd,
	input  wire krt_pkg::dp_status_t sts,
	output logic [1:0]               status_q
);
	import krt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH0, S_SRCH, S_DECIDE, S_RDOLD, S_OLD, S_WRITE,
		S_SHIFT0, S_SHIFT, S_RANK10, S_RANK1, S_RANK20, S_RANK2, S_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] req_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '{op: OP_IDLE, scan_start: 1'b0, drop_count: 1'b0,
			bump_count: 1'b0, capture_old: 1'b0};
		case (state_q)
			S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
			S_SRCH0:  begin cmd.op = OP_SEARCH; cmd.scan_start = 1'b1; end
			S_SRCH:   cmd.op = OP_SEARCH;
			S_RDOLD:  cmd.op = OP_READ;
			S_OLD:    cmd.capture_old = 1'b1;
			S_WRITE:  begin
				cmd.op = OP_WRITE;
				cmd.bump_count = (req_q == REQ_INSERT);
			end
			S_SHIFT0: begin cmd.op = OP_SHIFT; cmd.scan_start = 1'b1; end
			S_SHIFT:  begin
				cmd.op = OP_SHIFT;
				cmd.drop_count = sts.scan_done;
			end
			S_RANK10: begin cmd.op = OP_RANK1; cmd.scan_start = 1'b1; end
			S_RANK1:  cmd.op = OP_RANK1;
			S_RANK20: begin cmd.op = OP_RANK2; cmd.scan_start = 1'b1; end
			S_RANK2:  cmd.op = OP_RANK2;
			default:  cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= REQ_REPORT;
			status_q  <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					req_q    <= in_req;
					status_q <= ST_OK;
					state_q  <= (in_req == REQ_REPORT) ? S_RANK10 : S_SRCH0;
				end
				S_SRCH0: state_q <= S_SRCH;
				S_SRCH:  if (sts.scan_done) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (req_q == REQ_INSERT) begin
						if (sts.full) begin
							status_q <= ST_FULL; state_q <= S_RANK10;
						end else if (sts.found) begin
							status_q <= ST_DUPLICATE; state_q <= S_RANK10;
						end else begin
							state_q <= S_WRITE;
						end
					end else if (!sts.found) begin
						status_q <= ST_NOT_FOUND; state_q <= S_RANK10;
					end else begin
						state_q <= (req_q == REQ_UPDATE) ? S_RDOLD : S_SHIFT0;
					end
				end
				S_RDOLD: state_q <= S_OLD;
				S_OLD:   state_q <= S_WRITE;
				S_WRITE: state_q <= S_RANK10;
				S_SHIFT0: state_q <= S_SHIFT;
				S_SHIFT: if (sts.scan_done) state_q <= S_RANK10;
				S_RANK10: state_q <= S_RANK1;
				S_RANK1:  if (sts.scan_done) state_q <= S_RANK20;
				S_RANK20: state_q <= S_RANK2;
				S_RANK2:  if (sts.scan_done) begin
					state_q <= S_OUT; out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result outside output state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	a_one_count_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.bump_count && cmd.drop_count)) else $error("count up and down");
endmodule
`default_nettype wire

// ===== rtl/keyed_record_table_with_ranking.sv =====
// Top level of the keyed record table with ranking.
// Joins krt_ctrl and krt_datapath; depends on krt_pkg.
//
// Usage: one request item on the input channel (req_type, key, duration)
// gives one result item on the output channel. The block works on one item
// at a time: in_ready is high only while idle. Each item but a report takes
// one scan of the table for the key; then comes an optional write (after a
// read of the old value for an update) or a shift of the later entries (each
// moved entry is read, then written one place down), and two ranking scans,
// all through the single port of the key and value RAMs. The search and
// ranking scans read one entry per cycle. The result is held in registers
// with out_valid high until out_ready takes it, and the next item is accepted
// the cycle after. Reset clears the record count and the controller; the RAM
// contents need no clearing since only entries below the count are read.
// Keys compare on their low KEY_BITS bits.
`default_nettype none
module keyed_record_table_with_ranking #(
	parameter int unsigned ENTRIES  = 128,
	parameter int unsigned KEY_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key,
	input  wire logic [15:0] duration,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      old_duration,
	output logic [7:0]       entry_total,
	output logic [63:0]      min_key,
	output logic [15:0]      min_value,
	output logic [63:0]      max_key,
	output logic [15:0]      max_value,
	output logic [63:0]      second_min_key,
	output logic [15:0]      second_min_value,
	output logic [63:0]      second_max_key,
	output logic [15:0]      second_max_value
);
	import krt_pkg::*;

	dp_cmd_t             cmd;
	dp_status_t          sts;
	logic [KEY_BITS-1:0] mnk, mxk, smnk, smxk;
	logic [15:0]         mnv, mxv, smnv, smxv;
	logic                mn_ok, smn_ok, smx_ok;

	krt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .in_req(req_type),
		.cmd(cmd), .sts(sts), .status_q(status));

	krt_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_req(req_type), .in_key(key), .in_dur(duration),
		.old_q(old_duration), .total(entry_total),
		.mn_key_q(mnk), .mn_val_q(mnv), .mx_key_q(mxk), .mx_val_q(mxv),
		.smn_key_q(smnk), .smn_val_q(smnv), .smx_key_q(smxk), .smx_val_q(smxv),
		.mn_ok_q(mn_ok), .smn_ok_q(smn_ok), .smx_ok_q(smx_ok));

	// An empty table shows zeros; max exists exactly when min does.
	assign min_key          = mn_ok  ? 64'(mnk)  : '0;
	assign min_value        = mn_ok  ? mnv       : '0;
	assign max_key          = mn_ok  ? 64'(mxk)  : '0;
	assign max_value        = mn_ok  ? mxv       : '0;
	assign second_min_key   = smn_ok ? 64'(smnk) : '0;
	assign second_min_value = smn_ok ? smnv      : '0;
	assign second_max_key   = smx_ok ? 64'(smxk) : '0;
	assign second_max_value = smx_ok ? smxv      : '0;
endmodule
`default_nettype wire

// ===== test/krt_checker.sv =====
// Checker for the keyed record table: watches both channels, keeps its own
// table and ranking, and compares every result item. Depends on krt_pkg.
`default_nettype none
module krt_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key,
	input  wire logic [15:0] duration,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  status,
	input  wire logic [15:0] old_duration,
	input  wire logic [7:0]  entry_total,
	input  wire logic [63:0] min_key,
	input  wire logic [15:0] min_value,
	input  wire logic [63:0] max_key,
	input  wire logic [15:0] max_value,
	input  wire logic [63:0] second_min_key,
	input  wire logic [15:0] second_min_value,
	input  wire logic [63:0] second_max_key,
	input  wire logic [15:0] second_max_value,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import krt_pkg::*;

	localparam int DEPTH = 128;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] old_duration;
		logic [7:0]  entry_total;
		logic [63:0] keys [4];
		logic [15:0] vals [4];
	} table_result_t;

	logic [63:0] tbl_key [DEPTH];
	logic [15:0] tbl_dur [DEPTH];
	int          tbl_count;
	table_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic int find_key(logic [63:0] k);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_key[i] == k) return i;
		return -1;
	endfunction

	// earliest extreme entry, skipping one index; strict compares keep ties early
	function automatic int rank_pick(bit want_max, int skip);
		int best;
		best = -1;
		for (int i = 0; i < tbl_count; i++) begin
			if (i == skip) continue;
			if (best < 0) best = i;
			else if (want_max ? tbl_dur[i] > tbl_dur[best] : tbl_dur[i] < tbl_dur[best])
				best = i;
		end
		return best;
	endfunction

	function automatic table_result_t apply_request(logic [1:0] rt, logic [63:0] k,
			logic [15:0] d);
		table_result_t r;
		int idx;
		int sel [4];
		r.status = ST_OK;
		r.old_duration = '0;
		idx = find_key(k);
		case (rt)
			REQ_INSERT: begin
				if (tbl_count >= DEPTH) r.status = ST_FULL;
				else if (idx >= 0) r.status = ST_DUPLICATE;
				else begin
					tbl_key[tbl_count] = k;
					tbl_dur[tbl_count] = d;
					tbl_count++;
				end
			end
			REQ_UPDATE: begin
				if (idx < 0) r.status = ST_NOT_FOUND;
				else begin
					r.old_duration = tbl_dur[idx];
					tbl_dur[idx] = d;
				end
			end
			REQ_REMOVE: begin
				if (idx < 0) r.status = ST_NOT_FOUND;
				else begin
					for (int i = idx; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_dur[i] = tbl_dur[i + 1];
					end
					tbl_count--;
				end
			end
			default: ;
		endcase
		sel[0] = rank_pick(1'b0, -1);
		sel[1] = rank_pick(1'b1, -1);
		sel[2] = sel[0] >= 0 ? rank_pick(1'b0, sel[0]) : -1;
		sel[3] = sel[1] >= 0 ? rank_pick(1'b1, sel[1]) : -1;
		for (int j = 0; j < 4; j++) begin
			r.keys[j] = sel[j] < 0 ? '0 : tbl_key[sel[j]];
			r.vals[j] = sel[j] < 0 ? '0 : tbl_dur[sel[j]];
		end
		r.entry_total = tbl_count[7:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t r;
		if (!arst_n) begin
			tbl_count = 0;
			errors = 0;
			expected_results.delete();
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_request(req_type, key, duration));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no request outstanding");
					errors++;
				end else begin
					r = expected_results.pop_front();
					check_field("status", r.status, status);
					check_field("old_duration", r.old_duration, old_duration);
					check_field("entry_total", r.entry_total, entry_total);
					check_field("min_key", r.keys[0], min_key);
					check_field("min_value", r.vals[0], min_value);
					check_field("max_key", r.keys[1], max_key);
					check_field("max_value", r.vals[1], max_value);
					check_field("second_min_key", r.keys[2], second_min_key);
					check_field("second_min_value", r.vals[2], second_min_value);
					check_field("second_max_key", r.keys[3], second_max_key);
					check_field("second_max_value", r.vals[3], second_max_value);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_keyed_record_table_with_ranking.sv =====
// Testbench top for keyed_record_table_with_ranking: drives directed and
// random requests with random gaps and stalls; krt_checker does the checking.
`default_nettype none
module tb_keyed_record_table_with_ranking;
	timeunit 1ns;
	timeprecision 1ps;
	import krt_pkg::*;

	localparam int DEPTH = 128;
	localparam int RANDOM_ITEMS = 1630;
	localparam longint CYCLE_LIMIT = 10000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = REQ_REPORT;
	logic [63:0] key = '0;
	logic [15:0] duration = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] old_duration;
	logic [7:0]  entry_total;
	logic [63:0] min_key, max_key, second_min_key, second_max_key;
	logic [15:0] min_value, max_value, second_min_value, second_max_value;
	int          errors, pending;
	longint      cycles = 0;
	bit          stall_enable = 1'b1;
	logic [63:0] live_keys[$];

	always #10 clk = ~clk;

	keyed_record_table_with_ranking u_top (.*);

	krt_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("keyed_record_table_with_ranking: mismatch");
			$finish;
		end
	end

	function automatic int gap_length();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	// receiver stalls; off for stretches
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (stall_enable && $urandom_range(9) < 3) begin
				n = gap_length();
				if (n != 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
		end
	end

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(logic [1:0] rt, logic [63:0] k, logic [15:0] d);
		int i;
		req_type <= rt;
		key <= k;
		duration <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		// let the checker record the item before anything else is driven
		@(posedge clk);
		if (rt == REQ_INSERT && !(k inside {live_keys}) && live_keys.size() < DEPTH)
			live_keys.push_back(k);
		if (rt == REQ_REMOVE)
			for (i = 0; i < live_keys.size(); i++)
				if (live_keys[i] == k) begin
					live_keys.delete(i);
					break;
				end
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = gap_length();
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_key();
		if (live_keys.size() != 0 && $urandom_range(9) < 8)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		return rand_key();
	endfunction

	initial begin
		int r;
		logic [1:0] rt;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, one entry, ties, extremes, misses
		send_request(REQ_REPORT, '0, '0);
		send_request(REQ_UPDATE, 64'h1, 16'h5);
		send_request(REQ_REMOVE, 64'h1, '0);
		send_request(REQ_INSERT, '1, 16'hFFFF);
		send_request(REQ_INSERT, '1, 16'h1);
		send_request(REQ_INSERT, '0, 16'h0);
		send_request(REQ_INSERT, 64'hAAAA_5555_AAAA_5555, 16'hFFFF);
		send_request(REQ_INSERT, 64'h5555_AAAA_5555_AAAA, 16'h0);
		send_request(REQ_UPDATE, '1, 16'h8000);
		send_request(REQ_UPDATE, 64'h5555_AAAA_5555_AAAA, 16'h7FFF);
		send_request(REQ_REMOVE, '0, '0);
		send_request(REQ_REMOVE, 64'hAAAA_5555_AAAA_5555, '0);
		send_request(REQ_REMOVE, 64'h1234, '0);
		send_request(REQ_REPORT, 64'h77, 16'h9);
		drain();

		// fill to full, then try one more insert and a duplicate
		while (live_keys.size() < DEPTH)
			send_request(REQ_INSERT, rand_key(), 16'($urandom_range(65535)));
		send_request(REQ_INSERT, rand_key(), 16'h1);
		send_request(REQ_INSERT, live_keys[0], 16'h1);
		drain();
		while (live_keys.size() > 2)
			send_request(REQ_REMOVE, live_keys[$urandom_range(live_keys.size() - 1)], '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 600) begin
				stall_enable = 1'b0;
				drain();
			end
			if (n == 900) stall_enable = 1'b1;
			r = $urandom_range(99);
			// keep the table mostly small, narrow durations force ties
			if (r < 40 && live_keys.size() < 24) rt = REQ_INSERT;
			else if (r < 45) rt = REQ_INSERT;
			else if (r < 70) rt = REQ_UPDATE;
			else if (r < 88) rt = REQ_REMOVE;
			else rt = REQ_REPORT;
			send_request(rt, rt == REQ_INSERT && $urandom_range(9) < 8 ? rand_key() : pick_key(),
				$urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom));
			if ($urandom_range(3) == 0) idle_gap();
		end

		drain();
		repeat (700) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("keyed_record_table_with_ranking: match");
		else
			$display("keyed_record_table_with_ranking: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
